[sv/isort_pkg.sv]
// Shared types and constants of the insertion sorter.
// No dependencies; used by isort_cell, insertion_sorter, sorted_set_checker and tb.
package isort_pkg;

	localparam int VALUE_W       = 32;
	localparam int DEPTH_DEFAULT = 16;

	typedef logic signed [VALUE_W-1:0] value_t;

	// What a cell shows its neighbors
	typedef struct packed {
		value_t value;
		logic   valid;
		logic   shift;   // cell lies in the trailing run that moves up on insertion
	} link_t;

	// Broadcast control from the top level to every cell
	typedef struct packed {
		logic   insert;      // insert new_value this cycle (store not full)
		logic   drain;       // move every cell down by one toward cell 0
		logic   descending;
		value_t new_value;
	} ctrl_t;

endpackage

[sv/insertion_sorter.sv]
// Top level of the insertion sorter: a chain of isort_cell instances,
// the drain control and the output register. Depends on isort_pkg.
//
// The sorter keeps up to DEPTH signed 32-bit values in a chain of cells,
// always in order (ascending, or descending when the descending register is
// set). Every cell compares the incoming value with its own at the same time,
// so one input transaction is taken per clock while a set is being collected.
// Equal values keep arrival order. A value arriving when all DEPTH cells are
// full is dropped and the overflow bit is raised on every result of that set.
// When a transaction with last_in set is taken, its value is inserted first,
// then the whole set is shifted out of cell 0, one result per clock when the
// output side does not stall; last_out marks the final result. While the set
// drains, in_stall is high, so no new value is taken until the whole set has
// been shifted out.
// The descending register is applied to each insertion as it happens; write
// it only between sets.
module insertion_sorter #(
	parameter int DEPTH = isort_pkg::DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_wr_en,
	input  logic                      cfg_wr_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [31:0]        value,
	input  logic                      last_in,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [31:0]        sorted_value,
	output logic                      last_out,
	output logic                      overflow
);
	import isort_pkg::*;

	logic   descending_q;
	logic   draining_q;
	logic   dropped_q;
	logic   out_valid_q;
	value_t out_value_q;
	logic   out_last_q;
	logic   out_ovf_q;

	link_t  links [DEPTH];
	link_t  head_link;
	link_t  end_link;
	ctrl_t  ctrl;

	logic   in_accept;
	logic   full;
	logic   out_free;
	logic   drain_step;

	assign full      = links[DEPTH-1].valid;
	assign in_stall  = draining_q;
	assign in_accept = in_valid && !draining_q;
	assign out_free  = !out_valid_q || !out_stall;
	// While draining, advance the chain by one whenever the output register can take a result
	assign drain_step = draining_q && out_free;

	assign ctrl.insert     = in_accept && !full;
	assign ctrl.drain      = drain_step;
	assign ctrl.descending = descending_q;
	assign ctrl.new_value  = value;

	// Cell 0 sees a valid, non-moving neighbor in front; the last cell sees
	// an empty slot behind it.
	assign head_link.value = '0;
	assign head_link.valid = 1'b1;
	assign head_link.shift = 1'b0;
	assign end_link.value  = '0;
	assign end_link.valid  = 1'b0;
	assign end_link.shift  = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0 && DEPTH == 1) begin : g_only
			isort_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
				.from_prev(head_link), .from_next(end_link), .self(links[i])
			);
		end else if (i == 0) begin : g_first
			isort_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
				.from_prev(head_link), .from_next(links[i+1]), .self(links[i])
			);
		end else if (i == DEPTH-1) begin : g_last
			isort_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
				.from_prev(links[i-1]), .from_next(end_link), .self(links[i])
			);
		end else begin : g_mid
			isort_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
				.from_prev(links[i-1]), .from_next(links[i+1]), .self(links[i])
			);
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (cfg_wr_en) begin
			descending_q <= cfg_wr_data;
		end
	end

	// Collect / drain control and overflow tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			dropped_q  <= 1'b0;
		end else begin
			if (in_accept) begin
				if (full) begin
					dropped_q <= 1'b1;
				end
				if (last_in) begin
					draining_q <= 1'b1;
				end
			end
			// Final result leaves cell 0: the set is done, clear for the next one
			if (drain_step && !links[1 % DEPTH].valid) begin
				draining_q <= 1'b0;
				dropped_q  <= 1'b0;
			end
		end
	end

	// Output register: hold while stalled, load the head cell on each drain step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drain_step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_step) begin
			out_value_q <= links[0].value;
			out_last_q  <= (DEPTH == 1) ? 1'b1 : !links[1 % DEPTH].valid;
			out_ovf_q   <= dropped_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_value_q;
	assign last_out     = out_last_q;
	assign overflow     = out_ovf_q;

endmodule

[sv/isort_cell.sv]
// One cell of the insertion chain: holds one value and its valid bit.
// Depends on isort_pkg (link_t, ctrl_t).
module isort_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  isort_pkg::ctrl_t ctrl,
	input  isort_pkg::link_t from_prev,
	input  isort_pkg::link_t from_next,
	output isort_pkg::link_t self
);
	import isort_pkg::*;

	value_t value_q;
	logic   valid_q;
	logic   ahead;
	logic   tail;
	logic   write_en;

	// Strictly ahead: equal values stay behind held ones
	always_comb begin
		if (ctrl.descending) begin
			ahead = ctrl.new_value > value_q;
		end else begin
			ahead = ctrl.new_value < value_q;
		end
	end

	assign self.value = value_q;
	assign self.valid = valid_q;
	assign self.shift = valid_q && ahead && (!from_next.valid || from_next.shift);

	// First empty slot of the chain
	assign tail     = !valid_q && from_prev.valid;
	assign write_en = self.shift || tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.drain) begin
			valid_q <= from_next.valid;
		end else if (ctrl.insert && tail) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			value_q <= from_next.value;
		end else if (ctrl.insert && write_en) begin
			if (from_prev.shift) begin
				value_q <= from_prev.value;
			end else begin
				value_q <= ctrl.new_value;
			end
		end
	end

endmodule

[bench/sorted_set_checker.sv]
// Checker for the insertion sorter: predicts every sorted set and compares results.
// Watches the configuration port and both channels; depends on isort_pkg.
module sorted_set_checker #(
	parameter int DEPTH = isort_pkg::DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic signed [31:0]   value,
	input  logic                 last_in,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic signed [31:0]   sorted_value,
	input  logic                 last_out,
	input  logic                 overflow,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import isort_pkg::*;

	typedef struct packed {
		value_t sorted;
		logic   last;
		logic   ovf;
	} sorted_item_t;

	value_t       held [DEPTH];
	int           held_n;
	logic         dropped;
	logic         desc_order;
	sorted_item_t expected_sorted [$];
	int           fail_n;

	// True when a must sit strictly ahead of b; equal values keep arrival order.
	function automatic logic precedes(value_t a, value_t b, logic desc);
		return desc ? (a > b) : (a < b);
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			fail_n++;
			if (fail_n <= 30)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int           pos;
		sorted_item_t want;
		if (!arst_n) begin
			held_n = 0;
			dropped = 1'b0;
			desc_order = 1'b0;
			fail_n = 0;
			expected_sorted.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			// compare first: a result at this edge comes from older state
			if (out_valid && !out_stall) begin
				if (expected_sorted.size() == 0) begin
					fail_n++;
					if (fail_n <= 30)
						$display("%0t: result %0d with nothing expected", $time, sorted_value);
				end else begin
					want = expected_sorted.pop_front();
					check_field("sorted_value", want.sorted, sorted_value);
					check_field("last_out", want.last, last_out);
					check_field("overflow", want.ovf, overflow);
				end
			end
			if (in_valid && !in_stall) begin
				if (held_n == DEPTH) begin
					dropped = 1'b1;
				end else begin
					pos = held_n;
					while (pos > 0 && precedes(value, held[pos-1], desc_order)) begin
						held[pos] = held[pos-1];
						pos--;
					end
					held[pos] = value;
					held_n++;
				end
				if (last_in) begin
					for (int k = 0; k < held_n; k++) begin
						want.sorted = held[k];
						want.last = (k == held_n - 1);
						want.ovf = dropped;
						expected_sorted.push_back(want);
					end
					held_n = 0;
					dropped = 1'b0;
				end
			end
			if (cfg_wr_en)
				desc_order = cfg_wr_data;
			errors <= fail_n;
			pending <= expected_sorted.size();
		end
	end

endmodule

[bench/tb.sv]
// Top of the insertion sorter testbench: clock, reset, stimulus and verdict.
// Depends on isort_pkg, insertion_sorter and sorted_set_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import isort_pkg::*;

	localparam int DEPTH      = 16;
	localparam int IDLE_LIMIT = 1000;   // cycles with no transaction before giving up
	localparam int HOLD_LEN   = 150;    // long receiver hold-off
	localparam int PHASES     = 6;
	localparam int PHASE_ITEMS = 32;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic         cfg_wr_data = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_stall;
	value_t       value = '0;
	logic         last_in = 1'b0;
	logic         out_valid;
	logic         out_stall = 1'b0;
	value_t       sorted_value;
	logic         last_out;
	logic         overflow;

	int           errors;
	int           pending;
	int           cycles = 0;
	int           idle_cycles = 0;
	logic         calm = 1'b0;      // no idling on either side in the final phase
	logic         held_off = 1'b0;
	value_t       prev_value = '0;

	always #10 clk = ~clk;

	insertion_sorter #(.DEPTH(DEPTH)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.last_in      (last_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.overflow     (overflow)
	);

	sorted_set_checker #(.DEPTH(DEPTH)) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.last_in      (last_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.overflow     (overflow),
		.errors       (errors),
		.pending      (pending)
	);

	// Watchdog: count consecutive cycles in which no transaction moves.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off once a set is
	// draining, so the block holds its set with its input stalled.
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && !held_off && cycles >= 200 && out_valid) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Mix of full-range values, a narrow band that forces ties, extremes and repeats.
	function automatic value_t pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3, 4: return value_t'($urandom);
			5, 6, 7: return value_t'($signed($urandom_range(0, 15)) - 8);
			8: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return prev_value;
		endcase
	endfunction

	// Offer one transaction and hold it until taken; maybe idle afterwards.
	task automatic send_item(input value_t v, input logic l);
		in_valid <= 1'b1;
		value <= v;
		last_in <= l;
		prev_value = v;
		do @(posedge clk); while (in_stall);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic send_set(input int n);
		for (int i = 1; i <= n; i++)
			send_item(pick_value(), i == n);
	endtask

	// Drain everything outstanding, let the block settle, then write the order.
	task automatic set_order(input logic desc);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= desc;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int n;
		int phase_items;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ascending order, extremes and ties
		set_order(1'b0);
		send_item(32'sh7FFF_FFFF, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh0000_0000, 1'b0);
		send_item(32'shFFFF_FFFF, 1'b0);
		send_item(32'sh0000_0001, 1'b0);
		send_item(32'sh0000_0005, 1'b0);
		send_item(32'sh0000_0005, 1'b1);
		// set of one value
		send_item(32'shFFFF_FFFF, 1'b1);
		// store full: seventeenth value, the one marked last, is dropped
		for (int i = 0; i < 17; i++)
			send_item((i == 16) ? 32'sh8000_0000 : value_t'(100 - 7 * i), i == 16);

		// Random phases, flipping the order each time; the final one runs
		// with no idling at all.
		for (int ph = 0; ph < PHASES; ph++) begin
			set_order((ph % 2) == 0);
			if (ph == PHASES - 1)
				calm = 1'b1;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: n = $urandom_range(1, 6);
					6, 7: n = $urandom_range(7, DEPTH - 1);
					8: n = DEPTH;
					default: n = $urandom_range(DEPTH + 1, DEPTH + 4);
				endcase
				send_set(n);
				phase_items += n;
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
